/* rtl/mtep_pkg.sv */
// shared types and constants of the track event parser
package mtep_pkg;

	localparam int VAL_W = 28;
	localparam int DAT_W = 7;

	// parse phase of one track, held in the context store
	typedef enum logic [9:0] {
		PH_DELTA  = 10'b00_0000_0001,
		PH_STATUS = 10'b00_0000_0010,
		PH_DATA1  = 10'b00_0000_0100,
		PH_DATA2  = 10'b00_0000_1000,
		PH_MTYPE  = 10'b00_0001_0000,
		PH_MLEN   = 10'b00_0010_0000,
		PH_SXLEN  = 10'b00_0100_0000,
		PH_SKIP   = 10'b00_1000_0000,
		PH_TEMPO  = 10'b01_0000_0000,
		PH_ENDED  = 10'b10_0000_0000
	} phase_t;

	typedef enum logic [3:0] {
		EV_DELTA    = 4'd0,
		EV_NOTE_OFF = 4'd1,
		EV_NOTE_ON  = 4'd2,
		EV_VOLUME   = 4'd3,
		EV_PAN      = 4'd4,
		EV_VIBRATO  = 4'd5,
		EV_EXPR     = 4'd6,
		EV_RESET    = 4'd7,
		EV_CTLRESET = 4'd8,
		EV_ALLOFF   = 4'd9,
		EV_PROGRAM  = 4'd10,
		EV_PRESSURE = 4'd11,
		EV_BEND     = 4'd12,
		EV_TEMPO    = 4'd13,
		EV_END      = 4'd14
	} ev_kind_t;

	typedef struct packed {
		phase_t             phase;
		logic [7:0]         run_status;
		logic [VAL_W-1:0]   acc;
		logic [DAT_W-1:0]   first_data;
		logic [7:0]         meta_kind;
		logic [VAL_W-1:0]   remaining;
	} track_ctx_t;

	localparam track_ctx_t CTX_RESET = '{
		phase:      PH_DELTA,
		run_status: 8'h00,
		acc:        '0,
		first_data: '0,
		meta_kind:  8'h00,
		remaining:  '0
	};

	typedef struct packed {
		logic               valid;
		ev_kind_t           kind;
		logic [3:0]         channel;
		logic [DAT_W-1:0]   key;
		logic [DAT_W-1:0]   vel;
		logic [VAL_W-1:0]   value;
	} event_t;

	typedef struct packed {
		logic               en;
		logic [3:0]         channel;
		logic [DAT_W-1:0]   level;
	} vol_wr_t;

	// upper nibble of the status byte
	localparam logic [3:0] ST_NOTE_OFF = 4'h8;
	localparam logic [3:0] ST_NOTE_ON  = 4'h9;
	localparam logic [3:0] ST_CTRL     = 4'hB;
	localparam logic [3:0] ST_PROGRAM  = 4'hC;
	localparam logic [3:0] ST_PRESSURE = 4'hD;
	localparam logic [3:0] ST_BEND     = 4'hE;
	localparam logic [3:0] ST_SYSTEM   = 4'hF;

	localparam logic [7:0] STATUS_META = 8'hFF;
	localparam logic [7:0] META_END    = 8'h2F;
	localparam logic [7:0] TEMPO_META  = 8'h51;

	localparam logic [DAT_W-1:0] CC_MOD      = 7'd1;
	localparam logic [DAT_W-1:0] CC_VOLUME   = 7'd7;
	localparam logic [DAT_W-1:0] CC_PAN      = 7'd10;
	localparam logic [DAT_W-1:0] CC_EXPR     = 7'd11;
	localparam logic [DAT_W-1:0] CC_RESET    = 7'd120;
	localparam logic [DAT_W-1:0] CC_CTLRESET = 7'd121;
	localparam logic [DAT_W-1:0] CC_ALLOFF   = 7'd123;

	localparam logic [DAT_W-1:0] VOL_MAX = 7'd127;

endpackage

/* rtl/mtep_ctx_mem.sv */
// per-track parse context store with valid bits and write bypass
module mtep_ctx_mem import mtep_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  track_ctx_t      wr_data,
	output track_ctx_t      rd_ctx
);

	track_ctx_t        mem [DEPTH];
	track_ctx_t        rd_data_q;
	logic [AW-1:0]     rd_addr_q;
	logic              rd_valid_q;
	logic [DEPTH-1:0]  valid_q;
	track_ctx_t        byp_q;
	logic [AW-1:0]     byp_addr_q;
	logic              byp_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (wr_en) begin
			byp_q      <= wr_data;
			byp_addr_q <= wr_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_q  <= 1'b0;
			byp_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
				byp_valid_q      <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// a write in the same cycle as the read is not yet in the registered read data
	always_comb begin
		if (byp_valid_q && byp_addr_q == rd_addr_q) begin
			rd_ctx = byp_q;
		end else if (rd_valid_q) begin
			rd_ctx = rd_data_q;
		end else begin
			rd_ctx = CTX_RESET;
		end
	end

endmodule

/* rtl/mtep_decode.sv */
// next-context and event decode for one track-chunk byte
module mtep_decode import mtep_pkg::*; (
	input  logic [7:0]        data_byte,
	input  logic              track_start,
	input  track_ctx_t        ctx_rd,
	input  logic [DAT_W-1:0]  vol_level,
	output logic [3:0]        vol_ch,
	output track_ctx_t        ctx_nx,
	output event_t            evt,
	output vol_wr_t           vol_wr
);

	track_ctx_t        c;
	phase_t            eph;
	logic              status_data;
	logic [VAL_W-1:0]  acc_e;
	logic [VAL_W-1:0]  vl;
	logic [VAL_W-1:0]  tempo_acc;
	logic [VAL_W-1:0]  rem_dec;
	logic [3:0]        hi;
	logic [3:0]        ch;
	logic [DAT_W-1:0]  b7;
	logic [13:0]       prod;
	logic [DAT_W-1:0]  q_est;
	logic [7:0]        q_rem;
	logic [DAT_W-1:0]  scaled;

	function automatic phase_t status_route(input logic [7:0] s);
		phase_t p;
		if (s == STATUS_META) begin
			p = PH_MTYPE;
		end else if (s[7:4] == ST_SYSTEM) begin
			p = PH_SXLEN;
		end else begin
			p = PH_DATA1;
		end
		return p;
	endfunction

	assign c           = track_start ? CTX_RESET : ctx_rd;
	assign hi          = c.run_status[7:4];
	assign ch          = c.run_status[3:0];
	assign b7          = data_byte[6:0];
	assign vol_ch      = ch;
	assign status_data = (c.phase == PH_STATUS) && !data_byte[7];
	assign eph         = status_data ? status_route(c.run_status) : c.phase;
	assign acc_e       = status_data ? '0 : c.acc;
	assign vl          = {acc_e[VAL_W-8:0], b7};
	assign tempo_acc   = {acc_e[VAL_W-9:0], data_byte};
	assign rem_dec     = c.remaining - VAL_W'(1);

	// level * value / 127: quotient estimate by >>7, then one correction step
	assign prod   = 14'(vol_level) * 14'(b7);
	assign q_est  = prod[13:7];
	assign q_rem  = {1'b0, q_est} + {1'b0, prod[6:0]};
	assign scaled = q_est + DAT_W'(q_rem >= {1'b0, VOL_MAX});

	always_comb begin
		ctx_nx      = c;
		evt.valid   = 1'b0;
		evt.kind    = EV_DELTA;
		evt.channel = ch;
		evt.key     = '0;
		evt.vel     = '0;
		evt.value   = '0;
		vol_wr.en      = 1'b0;
		vol_wr.channel = ch;
		vol_wr.level   = b7;
		if (c.phase == PH_STATUS && data_byte[7]) begin
			ctx_nx.run_status = data_byte;
			ctx_nx.acc        = '0;
			ctx_nx.phase      = status_route(data_byte);
		end else begin
			if (status_data) begin
				ctx_nx.acc = '0;
			end
			case (eph)
				PH_DELTA: begin
					ctx_nx.acc = vl;
					if (!data_byte[7]) begin
						ctx_nx.acc   = '0;
						ctx_nx.phase = PH_STATUS;
						evt.valid    = 1'b1;
						evt.kind     = EV_DELTA;
						evt.channel  = 4'h0;
						evt.value    = vl;
					end
				end
				PH_DATA1: begin
					ctx_nx.first_data = b7;
					if (hi == ST_PROGRAM) begin
						ctx_nx.phase = PH_DELTA;
						evt.valid    = 1'b1;
						evt.kind     = EV_PROGRAM;
						evt.key      = b7;
					end else if (hi == ST_PRESSURE) begin
						ctx_nx.phase = PH_DELTA;
						evt.valid    = 1'b1;
						evt.kind     = EV_PRESSURE;
						evt.key      = b7;
						evt.value    = VAL_W'(scaled);
					end else begin
						ctx_nx.phase = PH_DATA2;
					end
				end
				PH_DATA2: begin
					ctx_nx.phase = PH_DELTA;
					case (hi)
						ST_NOTE_OFF: begin
							evt.valid = 1'b1;
							evt.kind  = EV_NOTE_OFF;
							evt.key   = c.first_data;
							evt.vel   = b7;
						end
						ST_NOTE_ON: begin
							evt.valid = 1'b1;
							evt.kind  = (b7 == '0) ? EV_NOTE_OFF : EV_NOTE_ON;
							evt.key   = c.first_data;
							evt.vel   = b7;
						end
						ST_CTRL: begin
							evt.key = b7;
							case (c.first_data)
								CC_MOD: begin
									evt.valid = 1'b1;
									evt.kind  = EV_VIBRATO;
								end
								CC_VOLUME: begin
									evt.valid = 1'b1;
									evt.kind  = EV_VOLUME;
									vol_wr.en = 1'b1;
								end
								CC_PAN: begin
									evt.valid = 1'b1;
									evt.kind  = EV_PAN;
								end
								CC_EXPR: begin
									evt.valid = 1'b1;
									evt.kind  = EV_EXPR;
									evt.value = VAL_W'(scaled);
								end
								CC_RESET: begin
									evt.valid = 1'b1;
									evt.kind  = EV_RESET;
								end
								CC_CTLRESET: begin
									evt.valid = 1'b1;
									evt.kind  = EV_CTLRESET;
								end
								CC_ALLOFF: begin
									evt.valid = 1'b1;
									evt.kind  = EV_ALLOFF;
								end
								default: begin
									evt.valid = 1'b0;
								end
							endcase
						end
						ST_BEND: begin
							evt.valid = 1'b1;
							evt.kind  = EV_BEND;
							evt.value = VAL_W'({b7, c.first_data});
						end
						default: begin
							evt.valid = 1'b0;
						end
					endcase
				end
				PH_MTYPE: begin
					ctx_nx.meta_kind = data_byte;
					ctx_nx.acc       = '0;
					ctx_nx.phase     = PH_MLEN;
				end
				PH_MLEN, PH_SXLEN: begin
					ctx_nx.acc = vl;
					if (!data_byte[7]) begin
						ctx_nx.acc       = '0;
						ctx_nx.remaining = vl;
						if (eph == PH_MLEN && c.meta_kind == META_END) begin
							ctx_nx.phase = PH_ENDED;
							evt.valid    = 1'b1;
							evt.kind     = EV_END;
						end else if (eph == PH_MLEN && c.meta_kind == TEMPO_META) begin
							if (vl == '0) begin
								ctx_nx.phase = PH_DELTA;
								evt.valid    = 1'b1;
								evt.kind     = EV_TEMPO;
							end else begin
								ctx_nx.phase = PH_TEMPO;
							end
						end else begin
							ctx_nx.phase = (vl != '0) ? PH_SKIP : PH_DELTA;
						end
					end
				end
				PH_SKIP: begin
					ctx_nx.remaining = rem_dec;
					if (rem_dec == '0) begin
						ctx_nx.phase = PH_DELTA;
					end
				end
				PH_TEMPO: begin
					ctx_nx.acc       = tempo_acc;
					ctx_nx.remaining = rem_dec;
					if (rem_dec == '0) begin
						ctx_nx.acc   = '0;
						ctx_nx.phase = PH_DELTA;
						evt.valid    = 1'b1;
						evt.kind     = EV_TEMPO;
						evt.value    = tempo_acc;
					end
				end
				default: begin
					ctx_nx = c;
				end
			endcase
		end
	end

endmodule

/* rtl/midi_track_event_parser.sv */
// each accepted byte is decoded in stage one; its event is registered onto the outputs
// throughput: one byte per cycle unless stalled; the context store has one read and one
//   write port; a write lands in a bypass register so that track may follow next cycle
// in_stall rises only while a byte that makes an event waits behind a stalled event
// reset: track contexts read as cleared through per-track valid bits (no clearing pass),
//   channel volumes go to 127, pipeline and output empty
module midi_track_event_parser import mtep_pkg::*; #(
	parameter int TRACK_SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic [3:0]         track_index,
	input  logic               track_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         event_kind,
	output logic [3:0]         event_track,
	output logic [3:0]         event_channel,
	output logic [DAT_W-1:0]   key_or_number,
	output logic [DAT_W-1:0]   velocity,
	output logic [VAL_W-1:0]   event_value
);

	localparam int AW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;

	logic [AW+3:0]     trk_ext;
	logic              in_range;
	logic              in_acc;

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic [3:0]        track_s1;
	logic              start_s1;
	logic              range_s1;
	logic [AW-1:0]     addr_s1;

	track_ctx_t        ctx_rd;
	track_ctx_t        ctx_nx;
	event_t            evt;
	vol_wr_t           vol_wr;
	logic [3:0]        vol_ch;
	logic [DAT_W-1:0]  vol_level;
	logic [DAT_W-1:0]  vol_q [16];

	logic              has_evt;
	logic              out_free;
	logic              adv;
	logic              out_valid_q;
	event_t            evt_q;
	logic [3:0]        track_q;

	assign trk_ext  = {{AW{1'b0}}, track_index};
	assign in_range = trk_ext < (AW+4)'(TRACK_SLOTS);
	assign in_acc   = in_valid && !in_stall;

	assign has_evt  = range_s1 && evt.valid;
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!has_evt || out_free);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1  <= data_byte;
			track_s1 <= track_index;
			start_s1 <= track_start;
			range_s1 <= in_range;
			addr_s1  <= trk_ext[AW-1:0];
		end
	end

	mtep_ctx_mem #(
		.DEPTH (TRACK_SLOTS),
		.AW    (AW)
	) u_ctx_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (trk_ext[AW-1:0]),
		.wr_en   (adv && range_s1),
		.wr_addr (addr_s1),
		.wr_data (ctx_nx),
		.rd_ctx  (ctx_rd)
	);

	mtep_decode u_decode (
		.data_byte   (data_s1),
		.track_start (start_s1),
		.ctx_rd      (ctx_rd),
		.vol_level   (vol_level),
		.vol_ch      (vol_ch),
		.ctx_nx      (ctx_nx),
		.evt         (evt),
		.vol_wr      (vol_wr)
	);

	// channel volume, shared by all tracks
	assign vol_level = vol_q[vol_ch];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				vol_q[i] <= VOL_MAX;
			end
		end else if (adv && range_s1 && vol_wr.en) begin
			vol_q[vol_wr.channel] <= vol_wr.level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && has_evt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_evt) begin
			evt_q   <= evt;
			track_q <= track_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = evt_q.kind;
	assign event_track   = track_q;
	assign event_channel = evt_q.channel;
	assign key_or_number = evt_q.key;
	assign velocity      = evt_q.vel;
	assign event_value   = evt_q.value;

endmodule

/* rtl/mtep_checker.sv */
// port-level checks for the track event parser, bound to the top level
module mtep_checker import mtep_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [3:0]         event_kind,
	input logic [3:0]         event_track,
	input logic [3:0]         event_channel,
	input logic [DAT_W-1:0]   key_or_number,
	input logic [DAT_W-1:0]   velocity,
	input logic [VAL_W-1:0]   event_value
);

	// a stalled transaction stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(event_value)
			&& $stable(event_track))
		else $error("stalled event changed");

	// with the output register empty nothing blocks the input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_vel_notes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && velocity != '0 |->
			(event_kind == EV_NOTE_OFF || event_kind == EV_NOTE_ON))
		else $error("velocity on a non-note event");

	// meta events only come under the 0xff running status
	a_meta_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_TEMPO || event_kind == EV_END) |->
			event_channel == 4'hF)
		else $error("meta event on wrong channel");

	a_delta_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_DELTA |->
			event_channel == 4'h0 && key_or_number == '0 && velocity == '0)
		else $error("delta event carries stray fields");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (.*);

/* tb/track_event_board_pkg.sv */
// scoreboard class for the track event parser: per-track event prediction and result checks
`timescale 1ns / 100ps
package track_event_board_pkg;
	import mtep_pkg::*;

	typedef struct packed {
		ev_kind_t           kind;
		logic [3:0]         track;
		logic [3:0]         channel;
		logic [DAT_W-1:0]   key;
		logic [DAT_W-1:0]   vel;
		logic [VAL_W-1:0]   value;
	} parsed_event_t;

	class track_event_board;
		track_ctx_t       ctx [16];
		logic [DAT_W-1:0] chan_level [16];
		parsed_event_t    due_events [$];
		int unsigned      errors;

		function new();
			foreach (ctx[i]) begin
				ctx[i] = CTX_RESET;
				chan_level[i] = VOL_MAX;
			end
			errors = 0;
		endfunction

		function logic [VAL_W-1:0] vlq_push(logic [VAL_W-1:0] acc, logic [7:0] b);
			return {acc[VAL_W-8:0], b[6:0]};
		endfunction

		function logic [VAL_W-1:0] level_of(logic [3:0] ch, logic [DAT_W-1:0] v);
			return VAL_W'((32'(chan_level[ch]) * 32'(v)) / 32'(VOL_MAX));
		endfunction

		function phase_t status_phase(logic [7:0] s);
			if (s == STATUS_META)
				return PH_MTYPE;
			if (s[7:4] == ST_SYSTEM)
				return PH_SXLEN;
			return PH_DATA1;
		endfunction

		// advances one track context by one byte, returns 1 when an event completes
		function bit decode_byte(logic [7:0] b, logic [3:0] t, logic s,
				output parsed_event_t ev);
			track_ctx_t       c;
			logic [3:0]       hi;
			logic [3:0]       ch;
			logic [DAT_W-1:0] d1;
			logic [DAT_W-1:0] d2;
			logic [VAL_W-1:0] v;
			bit               again;
			bit               hit;
			if (s)
				ctx[t] = CTX_RESET;
			c = ctx[t];
			hi = c.run_status[7:4];
			ch = c.run_status[3:0];
			ev = '0;
			ev.track = t;
			hit = 1'b0;
			do begin
				again = 1'b0;
				case (c.phase)
				PH_DELTA: begin
					c.acc = vlq_push(c.acc, b);
					if (!b[7]) begin
						ev.kind = EV_DELTA;
						ev.value = c.acc;
						c.acc = '0;
						c.phase = PH_STATUS;
						hit = 1'b1;
					end
				end
				PH_STATUS: begin
					c.acc = '0;
					if (b[7]) begin
						c.run_status = b;
						c.phase = status_phase(b);
					end else begin
						// running status: same byte goes through the next phase
						c.phase = status_phase(c.run_status);
						again = 1'b1;
					end
				end
				PH_DATA1: begin
					c.first_data = b[6:0];
					if (hi == ST_PROGRAM || hi == ST_PRESSURE) begin
						c.phase = PH_DELTA;
						ev.channel = ch;
						ev.key = b[6:0];
						hit = 1'b1;
						if (hi == ST_PROGRAM) begin
							ev.kind = EV_PROGRAM;
						end else begin
							ev.kind = EV_PRESSURE;
							ev.value = level_of(ch, b[6:0]);
						end
					end else begin
						c.phase = PH_DATA2;
					end
				end
				PH_DATA2: begin
					c.phase = PH_DELTA;
					d1 = c.first_data;
					d2 = b[6:0];
					ev.channel = ch;
					case (hi)
					ST_NOTE_OFF, ST_NOTE_ON: begin
						ev.kind = (hi == ST_NOTE_ON && d2 != 0) ? EV_NOTE_ON : EV_NOTE_OFF;
						ev.key = d1;
						ev.vel = d2;
						hit = 1'b1;
					end
					ST_CTRL: begin
						ev.key = d2;
						hit = 1'b1;
						case (d1)
						CC_MOD: ev.kind = EV_VIBRATO;
						CC_VOLUME: begin
							ev.kind = EV_VOLUME;
							chan_level[ch] = d2;
						end
						CC_PAN: ev.kind = EV_PAN;
						CC_EXPR: begin
							ev.kind = EV_EXPR;
							ev.value = level_of(ch, d2);
						end
						CC_RESET: ev.kind = EV_RESET;
						CC_CTLRESET: ev.kind = EV_CTLRESET;
						CC_ALLOFF: ev.kind = EV_ALLOFF;
						default: hit = 1'b0;
						endcase
					end
					ST_BEND: begin
						ev.kind = EV_BEND;
						ev.value = VAL_W'({d2, d1});
						hit = 1'b1;
					end
					default: ;
					endcase
				end
				PH_MTYPE: begin
					c.meta_kind = b;
					c.acc = '0;
					c.phase = PH_MLEN;
				end
				PH_MLEN, PH_SXLEN: begin
					c.acc = vlq_push(c.acc, b);
					if (!b[7]) begin
						v = c.acc;
						c.acc = '0;
						c.remaining = v;
						ev.channel = ch;
						if (c.phase == PH_MLEN && c.meta_kind == META_END) begin
							c.phase = PH_ENDED;
							ev.kind = EV_END;
							hit = 1'b1;
						end else if (c.phase == PH_MLEN && c.meta_kind == TEMPO_META
								&& v != 0) begin
							c.phase = PH_TEMPO;
						end else if (c.phase == PH_MLEN && c.meta_kind == TEMPO_META) begin
							// empty tempo body reports zero
							c.phase = PH_DELTA;
							ev.kind = EV_TEMPO;
							hit = 1'b1;
						end else begin
							c.phase = (v != 0) ? PH_SKIP : PH_DELTA;
						end
					end
				end
				PH_SKIP: begin
					c.remaining = c.remaining - 1'b1;
					if (c.remaining == 0)
						c.phase = PH_DELTA;
				end
				PH_TEMPO: begin
					c.acc = {c.acc[VAL_W-9:0], b};
					c.remaining = c.remaining - 1'b1;
					if (c.remaining == 0) begin
						ev.kind = EV_TEMPO;
						ev.channel = ch;
						ev.value = c.acc;
						c.acc = '0;
						c.phase = PH_DELTA;
						hit = 1'b1;
					end
				end
				default: ;
				endcase
			end while (again);
			ctx[t] = c;
			return hit;
		endfunction

		function void note_byte(logic [7:0] b, logic [3:0] t, logic s);
			parsed_event_t ev;
			if (decode_byte(b, t, s, ev))
				due_events.insert(due_events.size(), ev);
		endfunction

		function void check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_event(parsed_event_t got);
			parsed_event_t want;
			if (due_events.size() == 0) begin
				$error("event with none expected: kind %0d track %0d", got.kind, got.track);
				errors++;
				return;
			end
			want = due_events.pop_front();
			check_field("event_kind", VAL_W'(want.kind), VAL_W'(got.kind));
			check_field("event_track", VAL_W'(want.track), VAL_W'(got.track));
			check_field("event_channel", VAL_W'(want.channel), VAL_W'(got.channel));
			check_field("key_or_number", VAL_W'(want.key), VAL_W'(got.key));
			check_field("velocity", VAL_W'(want.vel), VAL_W'(got.vel));
			check_field("event_value", want.value, got.value);
		endfunction
	endclass

endpackage

/* tb/testbench.sv */
// testbench top for the track event parser: interleaved track streams, stalls and checks
`timescale 1ns / 100ps
module testbench;
	import mtep_pkg::*;
	import track_event_board_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1400;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam logic [3:0]  ST_POLY      = 4'hA;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         data_byte;
	logic [3:0]         track_index;
	logic               track_start;
	logic               out_valid;
	logic               out_stall;
	logic [3:0]         event_kind;
	logic [3:0]         event_track;
	logic [3:0]         event_channel;
	logic [DAT_W-1:0]   key_or_number;
	logic [DAT_W-1:0]   velocity;
	logic [VAL_W-1:0]   event_value;

	track_event_board board;

	// per-track byte streams waiting to go out: {ignored, start, byte}
	logic [9:0]  track_bytes [16][$];
	bit          need_start [16];
	logic [7:0]  last_status [16];
	int unsigned burst_left = 0;
	int unsigned holds_asked = 0;
	int unsigned cycle_count = 0;

	midi_track_event_parser uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin : result_monitor
		parsed_event_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = ev_kind_t'(event_kind);
			got.track = event_track;
			got.channel = event_channel;
			got.key = key_or_number;
			got.vel = velocity;
			got.value = event_value;
			board.check_event(got);
		end
	end

	// receiver stall pattern, with a long hold-off whenever one is asked for
	initial begin : rx_stall
		int unsigned mode;
		int unsigned left;
		int unsigned holds_done;
		mode = 0;
		left = 0;
		holds_done = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(10, 200);
				end
				left--;
				case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// one transaction per call; valid stays up across calls in a burst and may drop between bursts
	task automatic send_byte(input logic [7:0] b, input logic [3:0] t, input logic s);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		track_index <= t;
		track_start <= s;
		do @(posedge clk); while (in_stall);
		board.note_byte(b, t, s);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.due_events.size() != 0) @(posedge clk);
	endtask

	function automatic void queue_track_byte(int unsigned t, logic [7:0] b, bit ignored);
		track_bytes[t].insert(track_bytes[t].size(), {ignored, need_start[t], b});
		need_start[t] = 1'b0;
	endfunction

	function automatic void queue_length(int unsigned t, int unsigned len, bit pad);
		if (pad)
			queue_track_byte(t, 8'h80, 1'b0);
		queue_track_byte(t, 8'(len), 1'b0);
	endfunction

	function automatic logic [7:0] pick_data(bit may_flag);
		return {may_flag && $urandom_range(0, 19) == 0, 7'($urandom)};
	endfunction

	// appends one delta plus a message, not always well-formed or eventful, to a track's stream
	function automatic void build_message(int unsigned t);
		logic [7:0]       status;
		logic [7:0]       mtype;
		logic [DAT_W-1:0] cc;
		logic [3:0]       chan;
		int unsigned      pick;
		int unsigned      len;
		bit               fresh;
		pick = $urandom_range(0, 19);
		len = (pick < 12) ? 1 : (pick < 16) ? 2 : (pick < 18) ? 3 : (pick < 19) ? 4 : 5;
		for (int i = len; i > 0; i--)
			queue_track_byte(t, {i > 1, 7'($urandom)}, 1'b0);
		if (last_status[t] == 8'h00 && $urandom_range(0, 7) == 0) begin
			// data with no status yet: the pair is dropped
			queue_track_byte(t, {1'b0, 7'($urandom)}, 1'b0);
			queue_track_byte(t, 8'($urandom), 1'b0);
			return;
		end
		chan = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
		if (last_status[t] != 8'h00 && $urandom_range(0, 9) < 4) begin
			status = last_status[t];
			fresh = $urandom_range(0, 9) < 3;
		end else begin
			case ($urandom_range(0, 15))
			0, 1: status = {ST_NOTE_OFF, chan};
			2, 3, 4, 5: status = {ST_NOTE_ON, chan};
			6: status = {ST_POLY, chan};
			7, 8, 9: status = {ST_CTRL, chan};
			10: status = {ST_PROGRAM, chan};
			11: status = {ST_PRESSURE, chan};
			12: status = {ST_BEND, chan};
			13, 14: status = STATUS_META;
			default: status = 8'($urandom_range(8'hF0, 8'hFE));
			endcase
			fresh = 1'b1;
		end
		if (fresh)
			queue_track_byte(t, status, 1'b0);
		last_status[t] = status;
		// without a status byte the first data byte must keep its top bit clear
		case (status[7:4])
		ST_NOTE_OFF, ST_NOTE_ON, ST_POLY, ST_BEND: begin
			queue_track_byte(t, pick_data(fresh), 1'b0);
			if (status[7:4] == ST_NOTE_ON && $urandom_range(0, 5) == 0)
				queue_track_byte(t, 8'h00, 1'b0);
			else
				queue_track_byte(t, pick_data(1'b1), 1'b0);
		end
		ST_CTRL: begin
			case ($urandom_range(0, 9))
			0: cc = CC_MOD;
			1, 2: cc = CC_VOLUME;
			3: cc = CC_PAN;
			4, 5: cc = CC_EXPR;
			6: cc = CC_RESET;
			7: cc = CC_CTLRESET;
			8: cc = CC_ALLOFF;
			default: cc = 7'($urandom);
			endcase
			queue_track_byte(t, {fresh && $urandom_range(0, 19) == 0, cc}, 1'b0);
			queue_track_byte(t, pick_data(1'b1), 1'b0);
		end
		ST_PROGRAM, ST_PRESSURE: queue_track_byte(t, pick_data(fresh), 1'b0);
		default: begin
			if (status == STATUS_META) begin
				pick = $urandom_range(0, 11);
				mtype = (pick == 0) ? META_END : (pick < 6) ? TEMPO_META
					: {1'b0, 7'($urandom)};
				queue_track_byte(t, mtype, 1'b0);
				if (mtype == META_END)
					len = 0;
				else if (mtype == TEMPO_META)
					len = ($urandom_range(0, 1) == 0) ? 3 : $urandom_range(0, 5);
				else
					len = $urandom_range(0, 8);
				queue_length(t, len, $urandom_range(0, 5) == 0);
				for (int i = 0; i < len; i++)
					queue_track_byte(t, 8'($urandom), 1'b0);
				if (mtype == META_END) begin
					// an ended track swallows everything until the next start
					for (int i = $urandom_range(0, 2); i > 0; i--)
						queue_track_byte(t, 8'($urandom), 1'b1);
					need_start[t] = 1'b1;
					last_status[t] = 8'h00;
				end
			end else begin
				len = $urandom_range(0, 10);
				queue_length(t, len, fresh && $urandom_range(0, 3) == 0);
				for (int i = 0; i < len; i++)
					queue_track_byte(t, 8'($urandom), 1'b0);
			end
		end
		endcase
	endfunction

	initial begin : stimulus
		int unsigned cur;
		int unsigned items_sent;
		int unsigned pause_at;
		int unsigned hold_at;
		logic [9:0]  entry;
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		track_index = 4'd0;
		track_start = 1'b0;
		foreach (need_start[i]) begin
			need_start[i] = 1'b1;
			last_status[i] = 8'h00;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// five-byte delta, only the low 28 bits survive
		send_byte(8'hFF, 4'd15, 1'b1);
		send_byte(8'hFF, 4'd15, 1'b0);
		send_byte(8'hFF, 4'd15, 1'b0);
		send_byte(8'hFF, 4'd15, 1'b0);
		send_byte(8'h7F, 4'd15, 1'b0);
		// data with no status yet, both bytes dropped
		send_byte(8'h05, 4'd15, 1'b0);
		send_byte(8'h7F, 4'd15, 1'b0);
		// volume zero on channel 3, then pressure with a top-bit data byte
		send_byte(8'h00, 4'd15, 1'b0);
		send_byte(8'hB3, 4'd15, 1'b0);
		send_byte({1'b0, CC_VOLUME}, 4'd15, 1'b0);
		send_byte(8'h00, 4'd15, 1'b0);
		send_byte(8'h00, 4'd15, 1'b0);
		send_byte(8'hD3, 4'd15, 1'b0);
		send_byte(8'hFF, 4'd15, 1'b0);
		// end of track, then a byte the ended track must ignore
		send_byte(8'h00, 4'd15, 1'b0);
		send_byte(STATUS_META, 4'd15, 1'b0);
		send_byte(META_END, 4'd15, 1'b0);
		send_byte(8'h00, 4'd15, 1'b0);
		send_byte(8'h42, 4'd15, 1'b0);
		// largest three-byte tempo
		send_byte(8'h00, 4'd0, 1'b1);
		send_byte(STATUS_META, 4'd0, 1'b0);
		send_byte(TEMPO_META, 4'd0, 1'b0);
		send_byte(8'h03, 4'd0, 1'b0);
		send_byte(8'hFF, 4'd0, 1'b0);
		send_byte(8'hFF, 4'd0, 1'b0);
		send_byte(8'hFF, 4'd0, 1'b0);

		cur = 0;
		items_sent = 0;
		pause_at = 450;
		hold_at = 600;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= pause_at) begin
				wait_drained();
				pause_at += 450;
			end
			if (items_sent >= hold_at) begin
				holds_asked++;
				hold_at += 600;
			end
			if ($urandom_range(0, 24) == 0) begin
				// stray byte; that track's stream starts over afterwards
				cur = $urandom_range(0, 15);
				send_byte(8'($urandom), 4'(cur), $urandom_range(0, 3) == 0);
				track_bytes[cur].delete();
				need_start[cur] = 1'b1;
				last_status[cur] = 8'h00;
				items_sent++;
			end else begin
				if ($urandom_range(0, 3) == 0)
					cur = $urandom_range(0, 15);
				if (track_bytes[cur].size() == 0)
					build_message(cur);
				entry = track_bytes[cur].pop_front();
				send_byte(entry[7:0], 4'(cur), entry[8]);
				if (!entry[9])
					items_sent++;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
